FILE: rtl/rsmg_pkg.sv
// ----------------------------------------------------------------------------
// rsmg_pkg: shared types and tables for the run sequence mode guard
// Request and response payloads, mode codes and the mode transition table.
// ----------------------------------------------------------------------------
package rsmg_pkg;

  localparam int unsigned MODE_W     = 5;
  localparam int unsigned MODE_COUNT = 19;

  // Request operation codes
  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_EMPTY              = 5'd0;
  localparam logic [MODE_W-1:0] MODE_PARSING            = 5'd1;
  localparam logic [MODE_W-1:0] MODE_PARSED             = 5'd2;
  localparam logic [MODE_W-1:0] MODE_CLEARING           = 5'd3;
  localparam logic [MODE_W-1:0] MODE_REQ_LOAD           = 5'd4;
  localparam logic [MODE_W-1:0] MODE_PREP_LOAD          = 5'd5;
  localparam logic [MODE_W-1:0] MODE_LOADING            = 5'd6;
  localparam logic [MODE_W-1:0] MODE_LOADED             = 5'd7;
  localparam logic [MODE_W-1:0] MODE_REQ_PLAY           = 5'd8;
  localparam logic [MODE_W-1:0] MODE_PREP_PLAY          = 5'd9;
  localparam logic [MODE_W-1:0] MODE_WAIT_TRIG          = 5'd10;
  localparam logic [MODE_W-1:0] MODE_TRIGGERED          = 5'd11;
  localparam logic [MODE_W-1:0] MODE_PLAYING            = 5'd12;
  localparam logic [MODE_W-1:0] MODE_PAUSING            = 5'd13;
  localparam logic [MODE_W-1:0] MODE_PAUSED             = 5'd14;
  localparam logic [MODE_W-1:0] MODE_PREP_RESUME        = 5'd15;
  localparam logic [MODE_W-1:0] MODE_STOPPING           = 5'd16;
  localparam logic [MODE_W-1:0] MODE_REQ_PUBLISH        = 5'd17;
  localparam logic [MODE_W-1:0] MODE_PUBLISHING         = 5'd18;

  typedef logic [MODE_COUNT-1:0] mode_set_t;

  // Allowed destinations for each present mode (bit n = may move to mode n)
  localparam mode_set_t NEXT_ALLOWED [MODE_COUNT] = '{
    19'b001_0000_0000_0000_1010,  // empty
    19'b001_0000_0000_0000_0100,  // parsing
    19'b001_0000_0000_0001_1000,  // parsed
    19'b000_0000_0000_0000_0001,  // clearing
    19'b001_0000_0000_0010_0000,  // requesting load
    19'b001_0000_0000_0100_0000,  // preparing to load
    19'b001_0000_0000_1000_0000,  // loading
    19'b011_0000_0001_0000_1100,  // loaded
    19'b001_0000_0010_0000_0000,  // requesting play
    19'b001_0000_0100_0000_0000,  // preparing to play
    19'b001_0000_1000_0000_0000,  // waiting for trigger
    19'b001_0001_0000_0000_0000,  // triggered
    19'b001_0010_0100_0000_0000,  // playing
    19'b001_0100_0000_0000_0000,  // pausing
    19'b001_1000_0000_0000_0000,  // paused
    19'b001_0001_0000_0000_0000,  // preparing to resume
    19'b000_0000_0000_1000_0101,  // stopping
    19'b101_0000_0000_0000_0000,  // requesting publish
    19'b001_0000_0000_0000_0000   // publishing
  };

  typedef struct packed {
    logic              operation;
    logic [MODE_W-1:0] target_state;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [MODE_W-1:0] present_mode;
  } rsp_t;

  // Outcome of one request, from the step logic to the top level
  typedef struct packed {
    logic              accepted;
    logic [MODE_W-1:0] mode_nxt;
    logic [MODE_W-1:0] resting_nxt;
  } step_t;

  // Same-mode moves always pass, even for codes past the last mode; other moves with such a code never do
  function automatic logic move_allowed(logic [MODE_W-1:0] from_mode,
                                        logic [MODE_W-1:0] to_mode);
    logic ok;
    ok = 1'b0;
    if (from_mode == to_mode) begin
      ok = 1'b1;
    end else if ((from_mode < MODE_W'(MODE_COUNT)) && (to_mode < MODE_W'(MODE_COUNT))) begin
      ok = NEXT_ALLOWED[from_mode][to_mode];
    end
    return ok;
  endfunction

  function automatic logic is_resting(logic [MODE_W-1:0] m);
    return (m == MODE_EMPTY) || (m == MODE_PARSED) || (m == MODE_LOADED);
  endfunction

endpackage

FILE: rtl/rsmg_step.sv
// ----------------------------------------------------------------------------
// rsmg_step: next-mode logic
// Checks one request against the transition table and gives the outcome.
// ----------------------------------------------------------------------------
module rsmg_step (
  input  rsmg_pkg::req_t                   req,
  input  logic [rsmg_pkg::MODE_W-1:0]      mode_now,
  input  logic [rsmg_pkg::MODE_W-1:0]      resting_mode,
  output rsmg_pkg::step_t                  step
);
  import rsmg_pkg::*;

  always_comb begin
    step.accepted    = 1'b0;
    step.mode_nxt    = mode_now;
    step.resting_nxt = resting_mode;
    if (req.operation == OP_MOVE) begin
      // move: enter target if allowed, record it when it is a resting mode
      if (move_allowed(mode_now, req.target_state)) begin
        step.accepted = 1'b1;
        step.mode_nxt = req.target_state;
        if (is_resting(req.target_state)) begin
          step.resting_nxt = req.target_state;
        end
      end
    end else begin
      // leave: no-op unless the named mode is the present one
      if (mode_now != req.target_state) begin
        step.accepted = 1'b1;
      end else if (!is_resting(mode_now) && move_allowed(mode_now, resting_mode)) begin
        step.accepted = 1'b1;
        step.mode_nxt = resting_mode;
      end
    end
  end

endmodule

FILE: rtl/run_sequence_mode_guard.sv
// ----------------------------------------------------------------------------
// run_sequence_mode_guard: mode guard for an event playback engine
// Accepts move and leave requests and reports whether each one succeeded.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_req carry requests: a move to target_state, or a
//   leave of the mode named by target_state. A request is taken on a clock
//   edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_rsp carry one response per request: the accepted
//   flag and the mode after the request.
// Timing: a taken request passes the input register, then the response
//   register, where out_valid rises; the table check sits between them.
// Throughput: one request per cycle while out_stall is low.
// Reset: both mode registers return to empty and the pipeline drains empty.
// Stall: while out_stall holds a waiting response, the input register keeps
//   its request and in_stall rises once that register is full; nothing is
//   dropped and the mode only changes as a request enters the response
//   register.
// ----------------------------------------------------------------------------
module run_sequence_mode_guard (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rsmg_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output rsmg_pkg::rsp_t out_rsp
);
  import rsmg_pkg::*;

  logic              req_valid_r;
  req_t              req_r;
  logic              out_valid_r;
  rsp_t              rsp_r;
  logic [MODE_W-1:0] mode_r;
  logic [MODE_W-1:0] resting_r;
  step_t             step;
  logic              advance;
  logic              take_in;

  // Pipeline flow control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = req_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  rsmg_step u_step (
    .req          (req_r),
    .mode_now     (mode_r),
    .resting_mode (resting_r),
    .step         (step)
  );

  // Control and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_EMPTY;
      resting_r   <= MODE_EMPTY;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
        if (req_valid_r) begin
          mode_r    <= step.mode_nxt;
          resting_r <= step.resting_nxt;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      req_r <= in_req;
    end
    if (advance && req_valid_r) begin
      rsp_r.accepted     <= step.accepted;
      rsp_r.present_mode <= step.mode_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule
